@@ hw/rtl/otf_pkg.sv @@
// Shared constants, types and glyph ROM for the OLED text frame buffer.
package otf_pkg;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_PAGES  = 8;
	localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_PAGES;
	localparam int ADDR_W       = $clog2(STORE_BYTES);

	localparam int LINE_PITCH   = 11;
	localparam int SLOT_PITCH   = 7;
	localparam int LINE_COUNT   = 5;
	localparam int SLOT_COUNT   = 18;
	localparam int GLYPH_COLS   = 5;
	localparam int GLYPH_ROWS   = 7;
	localparam int BOLD_COLS    = GLYPH_COLS + 1;
	localparam int STREAM_HDR   = 3;
	localparam int QUEUE_DEPTH  = 2;

	// operation codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_FETCH = 2'd2;

	// queued work kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_CMD   = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	// stream header positions
	localparam logic [7:0] SIDX_PAGE   = 8'd0;
	localparam logic [7:0] SIDX_COL_LO = 8'd1;
	localparam logic [7:0] SIDX_COL_HI = 8'd2;

	localparam logic [3:0] CMD_PAGE_HI   = 4'hB;
	localparam logic [3:0] CMD_COL_LO_HI = 4'h0;
	localparam logic [3:0] CMD_COL_HI_HI = 4'h1;

	// configuration register indexes
	localparam logic [1:0] CFG_PANEL_READY   = 2'd0;
	localparam logic [1:0] CFG_COLUMN_OFFSET = 2'd1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [GLYPH_ROWS-1:0] gcol_t;
	typedef gcol_t [GLYPH_COLS-1:0] glyph_t;
	typedef gcol_t [BOLD_COLS-1:0] bold_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] cmd_byte;
		addr_t      addr;
		logic [6:0] x;
		logic [2:0] page0;
		logic [2:0] shift;
		bold_t      bold;
	} item_t;

	typedef struct packed {
		logic       panel_ready;
		logic [7:0] column_offset;
	} cfg_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic pop;
		logic init_busy;
	} back_status_t;

	function automatic glyph_t mk(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] c4);
		glyph_t g;
		g[0] = c0[GLYPH_ROWS-1:0];
		g[1] = c1[GLYPH_ROWS-1:0];
		g[2] = c2[GLYPH_ROWS-1:0];
		g[3] = c3[GLYPH_ROWS-1:0];
		g[4] = c4[GLYPH_ROWS-1:0];
		return g;
	endfunction

	function automatic glyph_t glyph_lookup(input logic [7:0] code);
		glyph_t g;
		unique case (code)
			8'h2D: g = mk(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
			8'h2E: g = mk(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
			8'h2F: g = mk(8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
			8'h30: g = mk(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
			8'h31: g = mk(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
			8'h32: g = mk(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
			8'h33: g = mk(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
			8'h34: g = mk(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
			8'h35: g = mk(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
			8'h36: g = mk(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
			8'h37: g = mk(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
			8'h38: g = mk(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
			8'h39: g = mk(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
			8'h41: g = mk(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
			8'h44: g = mk(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
			8'h45: g = mk(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
			8'h46: g = mk(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
			8'h48: g = mk(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
			8'h49: g = mk(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
			8'h4B: g = mk(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
			8'h4C: g = mk(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
			8'h4D: g = mk(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
			8'h4F: g = mk(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
			8'h50: g = mk(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
			8'h52: g = mk(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
			8'h53: g = mk(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
			8'h54: g = mk(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
			8'h55: g = mk(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
			8'h56: g = mk(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
			8'h57: g = mk(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
			8'h58: g = mk(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
			8'h59: g = mk(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

@@ hw/rtl/oled_text_framebuffer.sv @@
// Top level of the OLED text frame buffer: configuration registers and wiring.
//
//  channel   signals                                   direction
//  command   start, busy, operation .. stream_index    in  (start & !busy)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in  (valid & ready)
//  result    result_valid, stream_byte, is_data        out (one-cycle strobe)
//
// Clear: one store byte a cycle over all 1024 bytes. Draw: up to twelve pipelined
// read-modify-writes on the single store write port. Fetch: a command word comes
// straight from the queued item; a data word comes from a registered store read.
// After reset a clearing pass over the whole store runs with busy high.
// A two-deep queue lets commands be taken while the back end works; busy is high
// while it is full. Result words cannot be held off.
module oled_text_framebuffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [2:0] text_line,
	input  logic [4:0] char_slot,
	input  logic [7:0] char_code,
	input  logic [2:0] page_number,
	input  logic [7:0] stream_index,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       result_valid,
	output logic [7:0] stream_byte,
	output logic       is_data
);

	otf_pkg::cfg_t         cfg_q;
	otf_pkg::head_t        head;
	otf_pkg::back_status_t bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				otf_pkg::CFG_PANEL_READY:   cfg_q.panel_ready   <= cfg_data[0];
				otf_pkg::CFG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data;
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	otf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.text_line   (text_line),
		.char_slot   (char_slot),
		.char_code   (char_code),
		.page_number (page_number),
		.stream_index(stream_index),
		.cfg         (cfg_q),
		.bstat       (bstat),
		.head        (head)
	);

	otf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.bstat       (bstat),
		.result_valid(result_valid),
		.stream_byte (stream_byte),
		.is_data     (is_data)
	);

endmodule

@@ hw/rtl/otf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module otf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/otf_front.sv @@
// Front end: accepts commands, classifies them and queues work for the back end.
module otf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [2:0]           text_line,
	input  logic [4:0]           char_slot,
	input  logic [7:0]           char_code,
	input  logic [2:0]           page_number,
	input  logic [7:0]           stream_index,
	input  otf_pkg::cfg_t        cfg,
	input  otf_pkg::back_status_t bstat,
	output otf_pkg::head_t       head
);

	localparam int PTR_W = $clog2(otf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(otf_pkg::QUEUE_DEPTH + 1);

	otf_pkg::item_t  q_mem_q [otf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	otf_pkg::item_t  cls;
	otf_pkg::glyph_t glyph;
	logic            keep;
	logic            full;
	logic            push;
	logic [5:0]      y;
	int              col;

	always_comb begin
		cls   = '0;
		keep  = 1'b0;
		glyph = otf_pkg::glyph_lookup(char_code);
		y     = 6'(int'(text_line) * otf_pkg::LINE_PITCH);
		col   = int'(stream_index) - otf_pkg::STREAM_HDR;
		cls.x     = 7'(int'(char_slot) * otf_pkg::SLOT_PITCH);
		cls.page0 = y[5:3];
		cls.shift = y[2:0];
		for (int j = 0; j < otf_pkg::BOLD_COLS; j++) begin
			cls.bold[j] = '0;
			if (j < otf_pkg::GLYPH_COLS) begin
				cls.bold[j] = cls.bold[j] | glyph[j];
			end
			if (j > 0) begin
				cls.bold[j] = cls.bold[j] | glyph[j-1];
			end
		end
		unique case (operation)
			otf_pkg::OP_CLEAR: begin
				keep     = 1'b1;
				cls.kind = otf_pkg::KIND_CLEAR;
			end
			otf_pkg::OP_DRAW: begin
				keep = cfg.panel_ready && (int'(text_line) < otf_pkg::LINE_COUNT)
					&& (int'(char_slot) < otf_pkg::SLOT_COUNT);
				cls.kind = otf_pkg::KIND_DRAW;
			end
			otf_pkg::OP_FETCH: begin
				keep     = cfg.panel_ready && (int'(page_number) < otf_pkg::PANEL_PAGES);
				cls.kind = otf_pkg::KIND_CMD;
				cls.addr = otf_pkg::ADDR_W'(int'(page_number) * otf_pkg::PANEL_WIDTH + col);
				if (stream_index == otf_pkg::SIDX_PAGE) begin
					cls.cmd_byte = {otf_pkg::CMD_PAGE_HI, 1'b0, page_number};
				end else if (stream_index == otf_pkg::SIDX_COL_LO) begin
					cls.cmd_byte = {otf_pkg::CMD_COL_LO_HI, cfg.column_offset[3:0]};
				end else if (stream_index == otf_pkg::SIDX_COL_HI) begin
					cls.cmd_byte = {otf_pkg::CMD_COL_HI_HI, cfg.column_offset[7:4]};
				end else if (col < otf_pkg::PANEL_WIDTH) begin
					cls.kind = otf_pkg::KIND_DATA;
				end else begin
					keep = 1'b0;
				end
			end
			default: keep = 1'b0;
		endcase
	end

	assign full = (count_q == CNT_W'(otf_pkg::QUEUE_DEPTH));
	assign busy = full | bstat.init_busy;
	assign push = start & ~busy & keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(otf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (bstat.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(otf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, bstat.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(otf_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

@@ hw/rtl/otf_back.sv @@
// Back end: clears the store, ORs glyphs in and serves flush bytes.
module otf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  otf_pkg::head_t        head,
	output otf_pkg::back_status_t bstat,
	output logic                  result_valid,
	output logic [7:0]            stream_byte,
	output logic                  is_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_DRAW  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FRD   = 3'd4;

	localparam int         STEP_W    = $clog2(2 * otf_pkg::BOLD_COLS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * otf_pkg::BOLD_COLS - 1);

	logic [2:0]           state_q;
	logic                 init_q;
	otf_pkg::addr_t       cnt_q;
	logic [STEP_W-1:0]    step_q;
	logic [6:0]           dx_q;
	logic [2:0]           dpage_q;
	logic [2:0]           dshift_q;
	otf_pkg::bold_t       dbold_q;

	logic                 wr_en_s1;
	otf_pkg::addr_t       wr_addr_s1;
	logic [7:0]           wr_mask_s1;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_data_q;

	logic                 pop;
	logic [2:0]           colj;
	otf_pkg::gcol_t       bcol;
	logic [15:0]          win;
	logic [7:0]           mask;
	logic [3:0]           pg;
	logic [6:0]           cx;
	logic                 in_range;
	otf_pkg::addr_t       step_addr;

	logic                 ram_we;
	otf_pkg::addr_t       ram_waddr;
	logic [7:0]           ram_wdata;
	otf_pkg::addr_t       ram_raddr;
	logic [7:0]           ram_rdata;

	assign pop = (state_q == ST_IDLE) && head.valid;

	always_comb begin
		colj      = step_q[STEP_W-1:1];
		bcol      = dbold_q[colj];
		win       = {9'b0, bcol} << dshift_q;
		mask      = step_q[0] ? win[15:8] : win[7:0];
		pg        = {1'b0, dpage_q} + {3'b0, step_q[0]};
		cx        = dx_q + {4'b0, colj};
		in_range  = (int'(pg) < otf_pkg::PANEL_PAGES) && (int'(cx) < otf_pkg::PANEL_WIDTH);
		step_addr = otf_pkg::ADDR_W'(int'(pg) * otf_pkg::PANEL_WIDTH + int'(cx));
	end

	assign ram_raddr = (state_q == ST_DRAW) ? step_addr : head.item.addr;
	assign ram_we    = (state_q == ST_CLEAR) | wr_en_s1;
	assign ram_waddr = (state_q == ST_CLEAR) ? cnt_q : wr_addr_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? 8'h00 : (ram_rdata | wr_mask_s1);

	otf_ram #(
		.WIDTH(8),
		.DEPTH(otf_pkg::STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			step_q      <= '0;
			wr_en_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			wr_en_s1    <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						unique case (head.item.kind)
							otf_pkg::KIND_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							otf_pkg::KIND_DRAW: begin
								step_q  <= '0;
								state_q <= ST_DRAW;
							end
							otf_pkg::KIND_CMD: begin
								out_valid_q <= 1'b1;
							end
							otf_pkg::KIND_DATA: begin
								state_q <= ST_FRD;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == otf_pkg::ADDR_W'(otf_pkg::STORE_BYTES - 1)) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_DRAW: begin
					wr_en_s1 <= in_range;
					step_q   <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_FRD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= step_addr;
		wr_mask_s1 <= mask;
		if (pop) begin
			dx_q     <= head.item.x;
			dpage_q  <= head.item.page0;
			dshift_q <= head.item.shift;
			dbold_q  <= head.item.bold;
			out_byte_q <= head.item.cmd_byte;
			out_data_q <= 1'b0;
		end
		if (state_q == ST_FRD) begin
			out_byte_q <= ram_rdata;
			out_data_q <= 1'b1;
		end
	end

	assign bstat.pop       = pop;
	assign bstat.init_busy = init_q;
	assign result_valid    = out_valid_q;
	assign stream_byte     = out_byte_q;
	assign is_data         = out_data_q;

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_IDLE)
		else $error("drain not followed by idle");

	a_wr_stage: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> (state_q == ST_DRAW || state_q == ST_DRAIN))
		else $error("stray read-modify-write");

	a_frd_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRD |=> out_valid_q && out_data_q)
		else $error("data fetch gave no data word");

	a_init_clear: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> state_q == ST_CLEAR)
		else $error("left start-up clear early");

endmodule
